// ===== design/imi_pkg.sv =====
// Shared constants and cofactor index tables for the integer matrix inverse.
package imi_pkg;

  localparam int ELEMENT_WIDTH_DEF = 16;
  localparam int RESULT_WIDTH = 33;
  localparam int NUM_ENTRIES = 9;
  localparam int QUEUE_DEPTH = 4;

  // Adjugate entry k equals e[CF_A[k]] * e[CF_B[k]] - e[CF_C[k]] * e[CF_D[k]],
  // with elements numbered row-major from zero.
  localparam int CF_A [NUM_ENTRIES] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int CF_B [NUM_ENTRIES] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int CF_C [NUM_ENTRIES] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int CF_D [NUM_ENTRIES] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

// ===== design/imi_front.sv =====
// Front pipeline: captures a matrix and forms its adjugate and determinant.
module imi_front #(
  parameter int ELEMENT_WIDTH = imi_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_valid,
  output logic                                              in_ready,
  input  logic                                              in_three,
  input  logic [imi_pkg::NUM_ENTRIES*ELEMENT_WIDTH-1:0]     in_elems,
  output logic                                              out_valid,
  input  logic                                              out_ready,
  output logic [3*ELEMENT_WIDTH+2:0]                        out_det,
  output logic [imi_pkg::NUM_ENTRIES-1:0][2*ELEMENT_WIDTH:0] out_adj
);

  localparam int W = ELEMENT_WIDTH;
  localparam int N = imi_pkg::NUM_ENTRIES;
  localparam int AJ = 2 * W + 1;
  localparam int TW = 3 * W + 1;
  localparam int DTW = 3 * W + 3;

  logic v1, v2, v3, v4, v5;
  logic three1, three2, three3, three4;
  logic en;

  logic signed [W-1:0]    e1 [N];
  logic signed [W-1:0]    e2 [N];
  logic signed [2*W-1:0]  pp2 [N];
  logic signed [2*W-1:0]  pn2 [N];
  logic signed [W-1:0]    e3 [3];
  logic signed [AJ-1:0]   cof3 [3];
  logic signed [AJ-1:0]   adj3 [N];
  logic signed [AJ-1:0]   det2_3;
  logic signed [TW-1:0]   t4 [3];
  logic signed [AJ-1:0]   adj4 [N];
  logic signed [AJ-1:0]   det2_4;
  logic signed [DTW-1:0]  det5;
  logic signed [AJ-1:0]   adj5 [N];
  logic signed [AJ-1:0]   diff [N];

  assign en = !v5 || out_ready;
  assign in_ready = en;
  assign out_valid = v5;
  assign out_det = det5;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      diff[k] = AJ'(pp2[k]) - AJ'(pn2[k]);
      out_adj[k] = adj5[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      three1 <= in_three;
      three2 <= three1;
      three3 <= three2;
      three4 <= three3;
      for (int k = 0; k < N; k++) begin
        e1[k] <= in_elems[k*W +: W];
        e2[k] <= e1[k];
        pp2[k] <= e1[imi_pkg::CF_A[k]] * e1[imi_pkg::CF_B[k]];
        pn2[k] <= e1[imi_pkg::CF_C[k]] * e1[imi_pkg::CF_D[k]];
      end
      for (int k = 0; k < 3; k++) begin
        e3[k] <= e2[k];
        cof3[k] <= diff[3*k];
        t4[k] <= TW'(e3[k]) * TW'(cof3[k]);
      end
      det2_3 <= diff[8];
      if (three2) begin
        for (int k = 0; k < N; k++) begin
          adj3[k] <= diff[k];
        end
      end else begin
        for (int k = 0; k < N; k++) begin
          adj3[k] <= '0;
        end
        adj3[0] <= AJ'(e2[4]);
        adj3[1] <= -AJ'(e2[1]);
        adj3[3] <= -AJ'(e2[3]);
        adj3[4] <= AJ'(e2[0]);
      end
      adj4 <= adj3;
      det2_4 <= det2_3;
      adj5 <= adj4;
      if (three4) begin
        det5 <= DTW'(t4[0]) + DTW'(t4[1]) + DTW'(t4[2]);
      end else begin
        det5 <= DTW'(det2_4);
      end
    end
  end

endmodule

// ===== design/imi_queue.sv =====
// Short register queue between the front and back pipelines.
module imi_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = imi_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] count;

  assign full = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CW'(1))
    else $error("queue count did not grow on push");
`endif

endmodule

// ===== design/imi_back.sv =====
// Back pipeline: one restoring division step per stage for all nine entries.
module imi_back #(
  parameter int ELEMENT_WIDTH = imi_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                                                     clk,
  input  logic                                                     rst,
  input  logic                                                     in_valid,
  output logic                                                     in_ready,
  input  logic [3*ELEMENT_WIDTH+2:0]                               in_det,
  input  logic [imi_pkg::NUM_ENTRIES-1:0][2*ELEMENT_WIDTH:0]       in_adj,
  output logic                                                     out_valid,
  input  logic                                                     out_ready,
  output logic                                                     out_singular,
  output logic [imi_pkg::NUM_ENTRIES-1:0][imi_pkg::RESULT_WIDTH-1:0] out_res
);

  localparam int W = ELEMENT_WIDTH;
  localparam int N = imi_pkg::NUM_ENTRIES;
  localparam int RW = imi_pkg::RESULT_WIDTH;
  localparam int AJ = 2 * W + 1;
  localparam int AW = 2 * W;
  localparam int DTW = 3 * W + 3;
  localparam int DW = 3 * W + 2;
  localparam int XW = AW + RW;

  logic en;
  logic bv [AW+1];
  logic sg [AW+1];
  logic [DW-1:0] dm [AW+1];
  logic [N-1:0] ng [AW+1];
  logic [DW-1:0] rem [AW+1][N];
  logic [AW-1:0] num [AW+1][N];

  logic [DW-1:0] rem_next [AW+1][N];
  logic [AW-1:0] num_next [AW+1][N];
  logic [DW:0] sh [AW+1][N];
  logic [DW:0] df [AW+1][N];
  logic [AJ-1:0] absj [N];
  logic [DTW-1:0] absd;
  logic [XW-1:0] sq [N];

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    absd = in_det[DTW-1] ? DTW'(~in_det) + DTW'(1) : in_det;
    for (int k = 0; k < N; k++) begin
      absj[k] = in_adj[k][AJ-1] ? AJ'(~in_adj[k]) + AJ'(1) : in_adj[k];
      sq[k] = ng[AW][k] ? XW'(0) - XW'(num[AW][k]) : XW'(num[AW][k]);
    end
    for (int s = 0; s <= AW; s++) begin
      for (int k = 0; k < N; k++) begin
        sh[s][k] = '0;
        df[s][k] = '0;
        rem_next[s][k] = '0;
        num_next[s][k] = '0;
      end
    end
    for (int s = 1; s <= AW; s++) begin
      for (int k = 0; k < N; k++) begin
        sh[s][k] = {rem[s-1][k], num[s-1][k][AW-1]};
        df[s][k] = sh[s][k] - {1'b0, dm[s-1]};
        rem_next[s][k] = df[s][k][DW] ? sh[s][k][DW-1:0] : df[s][k][DW-1:0];
        num_next[s][k] = {num[s-1][k][AW-2:0], !df[s][k][DW]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= AW; s++) begin
        bv[s] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      bv[0] <= in_valid;
      for (int s = 1; s <= AW; s++) begin
        bv[s] <= bv[s-1];
      end
      out_valid <= bv[AW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg[0] <= (in_det == '0);
      dm[0] <= absd[DW-1:0];
      for (int k = 0; k < N; k++) begin
        ng[0][k] <= in_adj[k][AJ-1] ^ in_det[DTW-1];
        rem[0][k] <= '0;
        num[0][k] <= absj[k][AW-1:0];
      end
      for (int s = 1; s <= AW; s++) begin
        sg[s] <= sg[s-1];
        dm[s] <= dm[s-1];
        ng[s] <= ng[s-1];
        for (int k = 0; k < N; k++) begin
          rem[s][k] <= rem_next[s][k];
          num[s][k] <= num_next[s][k];
        end
      end
      out_singular <= sg[AW];
      for (int k = 0; k < N; k++) begin
        out_res[k] <= sg[AW] ? '0 : sq[k][RW-1:0];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_singular |-> out_res == '0)
    else $error("singular result carries nonzero entries");
  a_zero_divisor: assert property (@(posedge clk) disable iff (rst)
    bv[AW] && !sg[AW] |-> dm[AW] != '0)
    else $error("nonsingular item reached the end with a zero divisor");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    bv[AW] && en |=> out_valid)
    else $error("finished division did not reach the output register");
`endif

endmodule

// ===== design/integer_matrix_inverse.sv =====
// Top level of the adjugate-based 2x2 and 3x3 integer matrix inverse.
//
// Channel  Direction  tdata (low bit up)                     tuser
// s_*      in         m00 m01 m02 m10 m11 m12 m20 m21 m22    order_three
// m_*      out        r00 r01 r02 r10 r11 r12 r20 r21 r22    singular
//
// One matrix is taken per cycle while s_tready is high.
// The front takes five stages, the queue one, and the back one division step
// per quotient bit for 2*ELEMENT_WIDTH bits plus entry and output registers.
// Reset clears only the valid bits and the queue pointers and count. A stall
// on m_tready fills the queue before it reaches s_tready.
module integer_matrix_inverse #(
  parameter int ELEMENT_WIDTH = imi_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  input  logic [((imi_pkg::NUM_ENTRIES*ELEMENT_WIDTH+7)/8)*8-1:0] s_tdata,
  // order_three
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22
  output logic [((imi_pkg::NUM_ENTRIES*imi_pkg::RESULT_WIDTH+7)/8)*8-1:0] m_tdata,
  // singular
  output logic m_tuser
);

  localparam int W = ELEMENT_WIDTH;
  localparam int N = imi_pkg::NUM_ENTRIES;
  localparam int RW = imi_pkg::RESULT_WIDTH;
  localparam int AJ = 2 * W + 1;
  localparam int DTW = 3 * W + 3;
  localparam int QW = DTW + N * AJ;
  localparam int OW = ((N * RW + 7) / 8) * 8;

  logic f_valid, q_full, q_valid, b_ready;
  logic [DTW-1:0] f_det, q_det;
  logic [N-1:0][AJ-1:0] f_adj, q_adj;
  logic [N-1:0][RW-1:0] res;

  imi_front #(.ELEMENT_WIDTH(W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_three  (s_tuser),
    .in_elems  (s_tdata[N*W-1:0]),
    .out_valid (f_valid),
    .out_ready (!q_full),
    .out_det   (f_det),
    .out_adj   (f_adj)
  );

  imi_queue #(.WIDTH(QW), .DEPTH(imi_pkg::QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_valid && !q_full),
    .wdata ({f_adj, f_det}),
    .full  (q_full),
    .pop   (q_valid && b_ready),
    .valid (q_valid),
    .rdata ({q_adj, q_det})
  );

  imi_back #(.ELEMENT_WIDTH(W)) u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (q_valid),
    .in_ready     (b_ready),
    .in_det       (q_det),
    .in_adj       (q_adj),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_singular (m_tuser),
    .out_res      (res)
  );

  assign m_tdata = OW'(res);

endmodule

// ===== tb/sv/tb_integer_matrix_inverse.sv =====
// Self-checking testbench for the 2x2 and 3x3 integer matrix inverse.
module tb_integer_matrix_inverse;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ENTRIES = imi_pkg::NUM_ENTRIES;
  localparam int RESULT_WIDTH = imi_pkg::RESULT_WIDTH;
  localparam int EW = imi_pkg::ELEMENT_WIDTH_DEF;
  localparam int IN_W = ((NUM_ENTRIES * EW + 7) / 8) * 8;
  localparam int OUT_W = ((NUM_ENTRIES * RESULT_WIDTH + 7) / 8) * 8;
  localparam int LIMIT = 2000000;

  typedef struct {
    bit order_three;
    logic signed [EW-1:0] m [NUM_ENTRIES];
  } matrix_t;

  typedef struct {
    bit singular;
    logic signed [RESULT_WIDTH-1:0] r [NUM_ENTRIES];
  } inverse_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic m_tuser;

  integer_matrix_inverse u_dut (.*);

  matrix_t pending_matrices[$];
  inverse_t expected_inverses[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic inverse_t invert(matrix_t mx);
    inverse_t res;
    longint e [NUM_ENTRIES];
    longint adj [NUM_ENTRIES];
    longint det;
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      e[k] = mx.m[k];
      adj[k] = 0;
    end
    if (mx.order_three) begin
      det = e[0]*e[4]*e[8] + e[1]*e[5]*e[6] + e[2]*e[3]*e[7]
          - e[2]*e[4]*e[6] - e[0]*e[5]*e[7] - e[1]*e[3]*e[8];
      adj[0] = e[4]*e[8] - e[5]*e[7];
      adj[1] = e[2]*e[7] - e[1]*e[8];
      adj[2] = e[1]*e[5] - e[2]*e[4];
      adj[3] = e[5]*e[6] - e[3]*e[8];
      adj[4] = e[0]*e[8] - e[2]*e[6];
      adj[5] = e[2]*e[3] - e[0]*e[5];
      adj[6] = e[3]*e[7] - e[4]*e[6];
      adj[7] = e[1]*e[6] - e[0]*e[7];
      adj[8] = e[0]*e[4] - e[1]*e[3];
    end else begin
      det = e[0]*e[4] - e[1]*e[3];
      adj[0] = e[4];
      adj[1] = -e[1];
      adj[3] = -e[3];
      adj[4] = e[0];
    end
    res.singular = (det == 0);
    for (int k = 0; k < NUM_ENTRIES; k++)
      res.r[k] = res.singular ? '0 : RESULT_WIDTH'(adj[k] / det);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  function automatic logic signed [EW-1:0] rand_element();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return EW'($signed($urandom_range(0, 6)) - 3);
      3: return EW'($signed($urandom_range(0, 200)) - 100);
      default: return EW'($urandom);
    endcase
  endfunction

  task automatic add_matrix(bit three, logic signed [EW-1:0] v [NUM_ENTRIES]);
    matrix_t mx;
    mx.order_three = three;
    mx.m = v;
    pending_matrices.push_back(mx);
  endtask

  task automatic add_random(int n);
    logic signed [EW-1:0] v [NUM_ENTRIES];
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < NUM_ENTRIES; k++) v[k] = rand_element();
      // Some matrices get a repeated row so the singular path is taken often.
      if ($urandom_range(0, 7) == 0)
        for (int c = 0; c < 3; c++) v[3 + c] = v[c];
      add_matrix($urandom_range(0, 1), v);
    end
  endtask

  task automatic wait_drained();
    while (pending_matrices.size() != 0 || s_tvalid || expected_inverses.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_matrices.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        matrix_t mx;
        mx = pending_matrices.pop_front();
        for (int k = 0; k < NUM_ENTRIES; k++) s_tdata[k*EW +: EW] <= mx.m[k];
        s_tuser <= mx.order_three;
        s_tvalid <= 1'b1;
        expected_inverses.push_back(invert(mx));
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= !rst && ($urandom_range(0, 99) >= recv_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (expected_inverses.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        inverse_t want;
        want = expected_inverses.pop_front();
        if (m_tuser !== want.singular) report_mismatch("singular", m_tuser, want.singular);
        for (int k = 0; k < NUM_ENTRIES; k++)
          if (m_tdata[k*RESULT_WIDTH +: RESULT_WIDTH] !== want.r[k])
            report_mismatch($sformatf("r%0d%0d", k / 3, k % 3),
              $signed(m_tdata[k*RESULT_WIDTH +: RESULT_WIDTH]), want.r[k]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("[integer_matrix_inverse] ERROR");
      $finish;
    end
  end

  initial begin
    logic signed [EW-1:0] v [NUM_ENTRIES];
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // Directed: identity, extremes, singular cases, 2x2 with junk outside the block.
    v = '{1, 0, 0, 0, 1, 0, 0, 0, 1}; add_matrix(1, v); add_matrix(0, v);
    v = '{1, 2, 0, 3, 4, 0, 0, 0, 0}; add_matrix(0, v);
    v = '{1, 2, 3, 2, 4, 6, 7, 8, 9}; add_matrix(1, v);
    v = '{2, 4, -1, 1, 2, 5, 0, 0, 0}; add_matrix(0, v);
    v = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; add_matrix(1, v); add_matrix(0, v);
    for (int k = 0; k < NUM_ENTRIES; k++) v[k] = 16'sh7FFF;
    add_matrix(1, v); add_matrix(0, v);
    for (int k = 0; k < NUM_ENTRIES; k++) v[k] = 16'sh8000;
    add_matrix(1, v);
    v = '{16'sh8000, 0, 0, 0, 16'sh7FFF, 0, 0, 0, 1}; add_matrix(1, v);
    v = '{16'sh8000, 16'sh7FFF, 5, 16'sh7FFF, 16'sh8000, -5, 3, 2, 1}; add_matrix(1, v);
    v = '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
          16'sh8000, 16'sh8000, 16'sh8000};
    add_matrix(0, v);
    v = '{1, 0, 0, 0, 1, 0, 0, 0, 16'sh8000}; add_matrix(1, v);
    v = '{-1, -1, -1, -1, -1, -1, -1, -1, -1}; add_matrix(1, v);
    v = '{2, 1, 1, 1, 2, 1, 1, 1, 2}; add_matrix(1, v);
    v = '{-3, 7, 0, 5, 2, 0, 9, 9, 9}; add_matrix(0, v);
    wait_drained();
    send_idle_pct = 0;  recv_stall_pct = 0;  add_random(250); wait_drained();
    send_idle_pct = 79; recv_stall_pct = 0;  add_random(230); wait_drained();
    send_idle_pct = 0;  recv_stall_pct = 79; add_random(230); wait_drained();
    send_idle_pct = 36; recv_stall_pct = 36; add_random(240); wait_drained();
    repeat (2 * EW + 40) @(posedge clk);
    if (error_count == 0) begin
      $display("[integer_matrix_inverse] OK");
    end else begin
      $display("[integer_matrix_inverse] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/imi_pkg.sv
design/imi_front.sv
design/imi_queue.sv
design/imi_back.sv
design/integer_matrix_inverse.sv
tb/sv/tb_integer_matrix_inverse.sv
